>>> rtl/bpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Block padding codec package
// Shared widths, register indexes, mode codes, the result item type and the
// memory access type used by the padding codec modules.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int MAX_BLOCK = 32;
    localparam int SLOT_W    = $clog2(MAX_BLOCK);
    localparam int CNT_W     = $clog2(MAX_BLOCK + 1);
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_MODE       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 1'd1;

    localparam logic MODE_PAD   = 1'b0;
    localparam logic MODE_UNPAD = 1'b1;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;

    localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET = 6'd16;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              has;
        logic              last;
        logic              status;
    } item_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } ram_req_t;

    // Block size clamped to 1..MAX_BLOCK.
    function automatic logic [CNT_W-1:0] eff_block(input logic [CFG_W-1:0] size);
        logic [CNT_W-1:0] b;
        if (size == '0) begin
            b = CNT_W'(1);
        end else if (size > CFG_W'(MAX_BLOCK)) begin
            b = CNT_W'(MAX_BLOCK);
        end else begin
            b = CNT_W'(size);
        end
        return b;
    endfunction

endpackage
`default_nettype wire

>>> rtl/bpc_hold_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hold buffer memory
// One write port and one read port with registered read data. A read and a
// write of the same entry in one cycle return the old contents.
// ----------------------------------------------------------------------------
module bpc_hold_ram (
    input  wire logic                         aclk,
    input  wire bpc_pkg::ram_req_t            req,
    output logic [bpc_pkg::BYTE_W-1:0]        rdata
);

    logic [bpc_pkg::BYTE_W-1:0] mem [bpc_pkg::MAX_BLOCK];
    logic [bpc_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> rtl/bpc_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Result output register
// Holds one result item until the downstream transfer completes.
// ----------------------------------------------------------------------------
module bpc_out_stage (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bpc_pkg::item_t                emit,
    output logic                               out_free,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [bpc_pkg::BYTE_W-1:0]         m_out_byte,
    output logic                               m_out_has_byte,
    output logic                               m_out_last,
    output logic                               m_status
);

    logic                       valid_reg;
    logic [bpc_pkg::BYTE_W-1:0] byte_reg;
    logic                       has_reg;
    logic                       last_reg;
    logic                       status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (emit.valid) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit.valid) begin
            byte_reg   <= emit.data;
            has_reg    <= emit.has;
            last_reg   <= emit.last;
            status_reg <= emit.status;
        end
    end

    assign out_free       = !valid_reg || m_ready;
    assign m_valid        = valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_out_has_byte = has_reg;
    assign m_out_last     = last_reg;
    assign m_status       = status_reg;

endmodule
`default_nettype wire

>>> rtl/bpc_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Padding codec sequencer
// Holds the configuration and message counters, drives the hold buffer
// memory and sequences the padding, the padding check and the release.
// ----------------------------------------------------------------------------
module bpc_ctrl (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             cfg_we,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bpc_pkg::CFG_W-1:0]        cfg_wdata,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [bpc_pkg::BYTE_W-1:0]       s_data_byte,
    input  wire logic                             s_has_byte,
    input  wire logic                             s_msg_end,
    input  wire logic                             out_free,
    output bpc_pkg::item_t                        emit,
    output bpc_pkg::ram_req_t                     ram_req,
    input  wire logic [bpc_pkg::BYTE_W-1:0]       ram_rdata
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_POP     = 4'd1;
    localparam logic [3:0] ST_PAD     = 4'd2;
    localparam logic [3:0] ST_END_RD  = 4'd3;
    localparam logic [3:0] ST_END_P   = 4'd4;
    localparam logic [3:0] ST_CMP     = 4'd5;
    localparam logic [3:0] ST_REL_RD  = 4'd6;
    localparam logic [3:0] ST_REL_OUT = 4'd7;
    localparam logic [3:0] ST_FIN     = 4'd8;

    localparam int CNT_W  = bpc_pkg::CNT_W;
    localparam int SLOT_W = bpc_pkg::SLOT_W;
    localparam int BYTE_W = bpc_pkg::BYTE_W;

    logic [3:0]              state_reg, state_next;
    logic                    mode_reg, mode_next;
    logic [bpc_pkg::CFG_W-1:0] bsize_reg, bsize_next;
    logic [SLOT_W-1:0]       ws_reg, ws_next;
    logic [CNT_W-1:0]        phase_reg, phase_next;
    logic [CNT_W-1:0]        held_reg, held_next;
    logic                    seen_reg, seen_next;
    logic                    end_pend_reg, end_pend_next;
    logic                    ok_len_reg, ok_len_next;
    logic [CNT_W-1:0]        pad_left_reg, pad_left_next;
    logic [CNT_W-1:0]        pad_val_reg, pad_val_next;
    logic [BYTE_W-1:0]       p_reg, p_next;
    logic [CNT_W-1:0]        chk_back_reg, chk_back_next;
    logic [CNT_W-1:0]        rel_left_reg, rel_left_next;
    logic [SLOT_W-1:0]       rel_slot_reg, rel_slot_next;
    logic                    fin_status_reg, fin_status_next;

    logic [CNT_W-1:0]  bs;
    logic              accept;
    logic              pop;
    logic [CNT_W-1:0]  phase_inc;
    logic [CNT_W-1:0]  phase_new;
    logic [CNT_W-1:0]  held_new;
    logic              seen_new;
    logic              ok_len;
    logic [BYTE_W-1:0] p_sel;
    logic [CNT_W-1:0]  rel_cnt;
    logic              p_in_range;

    always_comb begin
        bs        = bpc_pkg::eff_block(bsize_reg);
        s_ready   = (state_reg == ST_IDLE) && out_free;
        accept    = s_valid && s_ready;
        pop       = (mode_reg == bpc_pkg::MODE_UNPAD) && s_has_byte && (held_reg >= bs);
        phase_inc = (phase_reg + CNT_W'(1) >= bs) ? '0 : phase_reg + CNT_W'(1);
        phase_new = s_has_byte ? phase_inc : phase_reg;
        if ((mode_reg == bpc_pkg::MODE_UNPAD) && s_has_byte && !pop) begin
            held_new = held_reg + CNT_W'(1);
        end else begin
            held_new = held_reg;
        end
        seen_new   = seen_reg || s_has_byte;
        ok_len     = seen_new && (phase_new == '0) && (held_new == bs);
        p_sel      = (state_reg == ST_END_P) ? ram_rdata : p_reg;
        rel_cnt    = bs - CNT_W'(p_sel);
        p_in_range = (ram_rdata != '0) && (ram_rdata <= BYTE_W'(bs));
    end

    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        bsize_next      = bsize_reg;
        ws_next         = ws_reg;
        phase_next      = phase_reg;
        held_next       = held_reg;
        seen_next       = seen_reg;
        end_pend_next   = end_pend_reg;
        ok_len_next     = ok_len_reg;
        pad_left_next   = pad_left_reg;
        pad_val_next    = pad_val_reg;
        p_next          = p_reg;
        chk_back_next   = chk_back_reg;
        rel_left_next   = rel_left_reg;
        rel_slot_next   = rel_slot_reg;
        fin_status_next = fin_status_reg;
        emit            = '0;
        ram_req         = '0;
        ram_req.waddr   = ws_reg;
        ram_req.wdata   = s_data_byte;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (mode_reg == bpc_pkg::MODE_PAD) begin
                        if (s_has_byte) begin
                            emit.valid = 1'b1;
                            emit.data  = s_data_byte;
                            emit.has   = 1'b1;
                        end
                        if (s_msg_end) begin
                            pad_left_next = bs - phase_new;
                            pad_val_next  = bs - phase_new;
                            phase_next    = '0;
                            seen_next     = 1'b0;
                            held_next     = '0;
                            ws_next       = '0;
                            state_next    = ST_PAD;
                        end else begin
                            phase_next = phase_new;
                            seen_next  = seen_new;
                        end
                    end else begin
                        if (s_has_byte) begin
                            ram_req.we = 1'b1;
                            ws_next    = ws_reg + SLOT_W'(1);
                        end
                        ram_req.re    = pop;
                        ram_req.raddr = ws_reg - SLOT_W'(held_reg);
                        phase_next    = phase_new;
                        held_next     = held_new;
                        seen_next     = seen_new;
                        end_pend_next = s_msg_end;
                        ok_len_next   = ok_len;
                        if (pop) begin
                            state_next = ST_POP;
                        end else if (s_msg_end) begin
                            if (ok_len) begin
                                state_next = ST_END_RD;
                            end else begin
                                fin_status_next = bpc_pkg::STATUS_BAD;
                                state_next      = ST_FIN;
                            end
                        end
                    end
                end
            end
            ST_POP: begin
                if (out_free) begin
                    emit.valid = 1'b1;
                    emit.data  = ram_rdata;
                    emit.has   = 1'b1;
                    if (!end_pend_reg) begin
                        state_next = ST_IDLE;
                    end else if (ok_len_reg) begin
                        state_next = ST_END_RD;
                    end else begin
                        fin_status_next = bpc_pkg::STATUS_BAD;
                        state_next      = ST_FIN;
                    end
                end
            end
            ST_PAD: begin
                if (out_free) begin
                    emit.valid    = 1'b1;
                    emit.data     = BYTE_W'(pad_val_reg);
                    emit.has      = 1'b1;
                    emit.last     = (pad_left_reg == CNT_W'(1));
                    pad_left_next = pad_left_reg - CNT_W'(1);
                    if (pad_left_reg == CNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_END_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = ws_reg - SLOT_W'(1);
                state_next    = ST_END_P;
            end
            ST_END_P: begin
                p_next = ram_rdata;
                if (!p_in_range) begin
                    fin_status_next = bpc_pkg::STATUS_BAD;
                    state_next      = ST_FIN;
                end else if (ram_rdata == BYTE_W'(1)) begin
                    if (rel_cnt == '0) begin
                        fin_status_next = bpc_pkg::STATUS_OK;
                        state_next      = ST_FIN;
                    end else begin
                        rel_left_next = rel_cnt;
                        rel_slot_next = ws_reg - SLOT_W'(held_reg);
                        state_next    = ST_REL_RD;
                    end
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ws_reg - SLOT_W'(2);
                    chk_back_next = CNT_W'(2);
                    state_next    = ST_CMP;
                end
            end
            ST_CMP: begin
                if (ram_rdata != p_reg) begin
                    fin_status_next = bpc_pkg::STATUS_BAD;
                    state_next      = ST_FIN;
                end else if (BYTE_W'(chk_back_reg) == p_reg) begin
                    if (rel_cnt == '0) begin
                        fin_status_next = bpc_pkg::STATUS_OK;
                        state_next      = ST_FIN;
                    end else begin
                        rel_left_next = rel_cnt;
                        rel_slot_next = ws_reg - SLOT_W'(held_reg);
                        state_next    = ST_REL_RD;
                    end
                end else begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = ws_reg - SLOT_W'(chk_back_reg + CNT_W'(1));
                    chk_back_next = chk_back_reg + CNT_W'(1);
                end
            end
            ST_REL_RD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = rel_slot_reg;
                state_next    = ST_REL_OUT;
            end
            ST_REL_OUT: begin
                if (out_free) begin
                    emit.valid    = 1'b1;
                    emit.data     = ram_rdata;
                    emit.has      = 1'b1;
                    emit.last     = (rel_left_reg == CNT_W'(1));
                    rel_left_next = rel_left_reg - CNT_W'(1);
                    rel_slot_next = rel_slot_reg + SLOT_W'(1);
                    if (rel_left_reg == CNT_W'(1)) begin
                        ws_next    = '0;
                        phase_next = '0;
                        held_next  = '0;
                        seen_next  = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_REL_RD;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    emit.valid  = 1'b1;
                    emit.last   = 1'b1;
                    emit.status = fin_status_reg;
                    ws_next     = '0;
                    phase_next  = '0;
                    held_next   = '0;
                    seen_next   = 1'b0;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A register write aborts any message in progress.
        if (cfg_we) begin
            if (cfg_index == bpc_pkg::REG_MODE) begin
                mode_next = cfg_wdata[0];
            end else begin
                bsize_next = cfg_wdata;
            end
            ws_next    = '0;
            phase_next = '0;
            held_next  = '0;
            seen_next  = 1'b0;
            state_next = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= bpc_pkg::MODE_PAD;
            bsize_reg <= bpc_pkg::BLOCK_SIZE_RESET;
            ws_reg    <= '0;
            phase_reg <= '0;
            held_reg  <= '0;
            seen_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            bsize_reg <= bsize_next;
            ws_reg    <= ws_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        end_pend_reg   <= end_pend_next;
        ok_len_reg     <= ok_len_next;
        pad_left_reg   <= pad_left_next;
        pad_val_reg    <= pad_val_next;
        p_reg          <= p_next;
        chk_back_reg   <= chk_back_next;
        rel_left_reg   <= rel_left_next;
        rel_slot_reg   <= rel_slot_next;
        fin_status_reg <= fin_status_next;
    end

endmodule
`default_nettype wire

>>> rtl/block_padding_codec.sv
`default_nettype none
// A pad-mode byte appears the cycle after its transfer; padding follows one byte a cycle while
// the output is free. Unpad mode: once a block is held, each byte also emits the oldest held
// byte through ST_POP. Unpad message end: ST_END_RD and ST_END_P fetch the pad byte, ST_CMP
// checks the other pad bytes, ST_REL_RD/ST_REL_OUT release bytes; a failed check gives one result.
// Reset (aresetn, synchronous, active low) clears control state, mode = pad, block size = 16;
// the hold buffer keeps its contents and is never read before it is written.
// ----------------------------------------------------------------------------
// Block padding codec
// Byte-stream block padder and unpadder with a configurable block size, built
// around a hold buffer memory, a sequencer and an output register.
// ----------------------------------------------------------------------------
module block_padding_codec (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [bpc_pkg::CFG_W-1:0]       cfg_wdata,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [bpc_pkg::BYTE_W-1:0]      s_data_byte,
    input  wire logic                            s_has_byte,
    input  wire logic                            s_msg_end,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [bpc_pkg::BYTE_W-1:0]           m_out_byte,
    output logic                                 m_out_has_byte,
    output logic                                 m_out_last,
    output logic                                 m_status
);

    bpc_pkg::item_t             emit;
    bpc_pkg::ram_req_t          ram_req;
    logic [bpc_pkg::BYTE_W-1:0] ram_rdata;
    logic                       out_free;

    bpc_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_has_byte  (s_has_byte),
        .s_msg_end   (s_msg_end),
        .out_free    (out_free),
        .emit        (emit),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

    bpc_hold_ram u_hold_ram (
        .aclk  (aclk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    bpc_out_stage u_out_stage (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .emit           (emit),
        .out_free       (out_free),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_out_has_byte (m_out_has_byte),
        .m_out_last     (m_out_last),
        .m_status       (m_status)
    );

endmodule
`default_nettype wire

>>> rtl/bpc_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Padding codec port checker
// Watches the result channel of the codec for stalls, for results that
// carry no byte and for the form of error results.
// ----------------------------------------------------------------------------
module bpc_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [bpc_pkg::BYTE_W-1:0]  m_out_byte,
    input wire logic                        m_out_has_byte,
    input wire logic                        m_out_last,
    input wire logic                        m_status
);

    // A stalled result holds until its transfer.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_out_has_byte)
            && $stable(m_out_last) && $stable(m_status))
        else $error("result changed while stalled");

    // A result without a byte always closes the message.
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_has_byte |-> m_out_last)
        else $error("empty result not marked last");

    // An error result carries no byte and closes the message.
    a_error_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> !m_out_has_byte && m_out_last)
        else $error("malformed error result");

    // A result without a byte shows a zero byte.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_out_has_byte |-> m_out_byte == '0)
        else $error("empty result with nonzero byte");

endmodule

bind block_padding_codec bpc_checker u_bpc_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_byte     (m_out_byte),
    .m_out_has_byte (m_out_has_byte),
    .m_out_last     (m_out_last),
    .m_status       (m_status)
);
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Block padding codec testbench
// Feeds byte streams in pad and unpad mode at several block sizes, predicts
// every result item with an in-bench padding model and compares each result
// transfer field by field, under random gaps and back pressure on both sides.
// ----------------------------------------------------------------------------
module tb;

    localparam int      BYTE_W          = bpc_pkg::BYTE_W;
    localparam int      CFG_W           = bpc_pkg::CFG_W;
    localparam int      CFG_IDX_W       = bpc_pkg::CFG_IDX_W;
    localparam int      MAX_BLOCK       = bpc_pkg::MAX_BLOCK;
    localparam int      HALF_PERIOD     = 6;
    localparam int      QUIET_CYCLES    = 40;
    localparam int      HOLD_OFF_CYCLES = 300;
    localparam int      RANDOM_ITEMS    = 70;
    localparam int      DRAIN_LIMIT     = 100000;
    localparam longint  RUN_LIMIT_NS    = 64'd15_000_000;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              has_byte;
        logic              last;
        logic              status;
    } codec_result_t;

    class padding_scoreboard;
        codec_result_t     expected_q[$];
        logic [BYTE_W-1:0] held[MAX_BLOCK];
        int unsigned       wr_slot;
        int unsigned       phase;
        int unsigned       held_n;
        bit                seen;
        logic              mode;
        logic [CFG_W-1:0]  size_reg;
        int unsigned       errors;

        function new();
            mode = bpc_pkg::MODE_PAD;
            size_reg = bpc_pkg::BLOCK_SIZE_RESET;
            errors = 0;
            clear_msg();
        endfunction

        function void clear_msg();
            wr_slot = 0;
            phase = 0;
            held_n = 0;
            seen = 1'b0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function int unsigned block_len();
            if (size_reg == 0) begin
                return 1;
            end
            if (size_reg > MAX_BLOCK) begin
                return MAX_BLOCK;
            end
            return size_reg;
        endfunction

        function int unsigned back_slot(int unsigned back);
            int unsigned b;
            b = back % MAX_BLOCK;
            return (wr_slot >= b) ? wr_slot - b : wr_slot + MAX_BLOCK - b;
        endfunction

        function logic [BYTE_W-1:0] pop_oldest();
            logic [BYTE_W-1:0] v;
            v = held[back_slot(held_n)];
            held_n--;
            return v;
        endfunction

        function void push(logic [BYTE_W-1:0] v, logic h, logic l, logic st);
            codec_result_t r;
            r.value = v;
            r.has_byte = h;
            r.last = l;
            r.status = st;
            expected_q.push_back(r);
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == bpc_pkg::REG_MODE) begin
                mode = val[0];
            end else if (idx == bpc_pkg::REG_BLOCK_SIZE) begin
                size_reg = val;
            end
            clear_msg();
        endfunction

        function void note_input(logic [BYTE_W-1:0] b, logic h, logic e);
            int unsigned bs;
            int unsigned padn;
            int unsigned p;
            int unsigned rel;
            bit          ok;
            bs = block_len();
            if (h) begin
                if (mode == bpc_pkg::MODE_PAD) begin
                    push(b, 1'b1, 1'b0, bpc_pkg::STATUS_OK);
                end else begin
                    if (held_n >= bs) begin
                        push(pop_oldest(), 1'b1, 1'b0, bpc_pkg::STATUS_OK);
                    end
                    held[wr_slot] = b;
                    wr_slot = (wr_slot + 1) % MAX_BLOCK;
                    held_n++;
                end
                phase = (phase + 1 >= bs) ? 0 : phase + 1;
                seen = 1'b1;
            end
            if (!e) begin
                return;
            end
            if (mode == bpc_pkg::MODE_PAD) begin
                padn = bs - phase;
                for (int i = 0; i < padn; i++) begin
                    push(BYTE_W'(padn), 1'b1, i == padn - 1, bpc_pkg::STATUS_OK);
                end
            end else begin
                ok = seen && phase == 0 && held_n == bs;
                p = 0;
                if (ok) begin
                    p = held[back_slot(1)];
                    ok = p >= 1 && p <= bs;
                end
                if (ok) begin
                    for (int i = 1; i <= p; i++) begin
                        if (held[back_slot(i)] != p) begin
                            ok = 1'b0;
                        end
                    end
                end
                if (ok) begin
                    rel = held_n - p;
                    if (rel == 0) begin
                        push('0, 1'b0, 1'b1, bpc_pkg::STATUS_OK);
                    end else begin
                        for (int i = 0; i < rel; i++) begin
                            push(pop_oldest(), 1'b1, i == rel - 1, bpc_pkg::STATUS_OK);
                        end
                    end
                end else begin
                    push('0, 1'b0, 1'b1, bpc_pkg::STATUS_BAD);
                end
            end
            clear_msg();
        endfunction

        function void check_result(codec_result_t got);
            codec_result_t want;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result: byte %02h has %0b last %0b status %0b",
                               got.value, got.has_byte, got.last, got.status));
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                flag($sformatf({"result mismatch: expected byte %02h has %0b last %0b ",
                                "status %0b, got byte %02h has %0b last %0b status %0b"},
                               want.value, want.has_byte, want.last, want.status,
                               got.value, got.has_byte, got.last, got.status));
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;
    logic                 s_valid;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_data_byte;
    logic                 s_has_byte;
    logic                 s_msg_end;
    logic                 m_valid;
    logic                 m_ready;
    logic [BYTE_W-1:0]    m_out_byte;
    logic                 m_out_has_byte;
    logic                 m_out_last;
    logic                 m_status;

    padding_scoreboard    sb;
    logic [BYTE_W-1:0]    msg_q[$];
    int unsigned          items_sent;
    bit                   in_gaps_on;
    bit                   out_gaps_on;
    bit                   hold_off_req;

    block_padding_codec dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_has_byte     (s_has_byte),
        .s_msg_end      (s_msg_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_out_has_byte (m_out_has_byte),
        .m_out_last     (m_out_last),
        .m_status       (m_status)
    );

    initial begin
        aclk = 1'b0;
    end

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic int pick_gap(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    task automatic send_item(input logic [BYTE_W-1:0] b, input logic h, input logic e);
        int gap;
        gap = pick_gap(in_gaps_on);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data_byte <= b;
        s_has_byte <= h;
        s_msg_end <= e;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(b, h, e);
        if (h || e) begin
            items_sent++;
        end
    endtask

    task automatic send_msg(input bit end_apart, input bit with_idle);
        int n;
        n = msg_q.size();
        for (int i = 0; i < n; i++) begin
            if (with_idle && $urandom_range(0, 15) == 0) begin
                send_item(BYTE_W'($urandom), 1'b0, 1'b0);
            end
            send_item(msg_q[i], 1'b1, !end_apart && i == n - 1);
        end
        if (end_apart || n == 0) begin
            send_item(BYTE_W'($urandom), 1'b0, 1'b1);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_register(idx, val);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic mode, input logic [CFG_W-1:0] size);
        wait_idle();
        if ($urandom_range(0, 1) == 0) begin
            write_reg(bpc_pkg::REG_MODE, CFG_W'(mode));
            write_reg(bpc_pkg::REG_BLOCK_SIZE, size);
        end else begin
            write_reg(bpc_pkg::REG_BLOCK_SIZE, size);
            write_reg(bpc_pkg::REG_MODE, CFG_W'(mode));
        end
    endtask

    task automatic build_pad(input int unsigned bs);
        int unsigned len;
        len = $urandom_range(0, (bs <= 8) ? 3 * bs : bs + 4);
        msg_q.delete();
        repeat (len) msg_q.push_back(BYTE_W'($urandom));
    endtask

    task automatic build_unpad(input int unsigned bs);
        int unsigned nblk;
        int unsigned p;
        int unsigned total;
        int unsigned idx;
        int          kind;
        nblk = (bs <= 8) ? $urandom_range(1, 3) : 1;
        p = $urandom_range(1, bs);
        total = nblk * bs;
        msg_q.delete();
        repeat (total - p) msg_q.push_back(BYTE_W'($urandom));
        repeat (p) msg_q.push_back(BYTE_W'(p));
        kind = $urandom_range(0, 19);
        case (kind)
            0, 1: begin
                idx = $urandom_range(total - p, total - 1);
                msg_q[idx] = msg_q[idx] ^ (BYTE_W'(1) << $urandom_range(0, 7));
            end
            2: begin
                msg_q.push_front(BYTE_W'($urandom));
            end
            3: begin
                void'(msg_q.pop_front());
            end
            4: begin
                msg_q[total - 1] = '0;
            end
            5: begin
                msg_q[total - 1] = BYTE_W'($urandom_range(bs + 1, 255));
            end
            6: begin
                msg_q.delete();
            end
            default: begin
            end
        endcase
    endtask

    initial begin : result_sink
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else begin
                gap = pick_gap(out_gaps_on);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result({m_out_byte, m_out_has_byte, m_out_last, m_status});
        end
    end

    initial begin : run_limit
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int unsigned       random_end;
        int unsigned       phase_idx;
        int unsigned       drain;
        logic              mode;
        logic [CFG_W-1:0]  size;
        int                r;
        sb = new();
        items_sent = 0;
        in_gaps_on = 1'b1;
        out_gaps_on = 1'b1;
        hold_off_req = 1'b0;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_data_byte <= '0;
        s_has_byte <= 1'b0;
        s_msg_end <= 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: pad mode with a block of 16.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'hA5, 1'b0, 1'b0);
        wait_idle();
        write_reg(bpc_pkg::REG_BLOCK_SIZE, 6'd0);
        send_item(8'h3C, 1'b1, 1'b1);
        wait_idle();
        write_reg(bpc_pkg::REG_BLOCK_SIZE, 6'd63);
        send_item(8'h00, 1'b0, 1'b1);

        apply_settings(bpc_pkg::MODE_UNPAD, 6'd4);
        msg_q = '{8'hAA, 8'hBB, 8'h02, 8'h02};
        send_msg(1'b0, 1'b0);
        msg_q = '{8'h04, 8'h04, 8'h04, 8'h04};
        send_msg(1'b0, 1'b0);
        msg_q.delete();
        send_msg(1'b0, 1'b0);
        msg_q = '{8'h01, 8'h01, 8'h01};
        send_msg(1'b0, 1'b0);
        wait_idle();
        write_reg(bpc_pkg::REG_BLOCK_SIZE, 6'd2);
        msg_q = '{8'h00, 8'h00};
        send_msg(1'b0, 1'b0);
        msg_q = '{8'h03, 8'h03};
        send_msg(1'b0, 1'b0);
        msg_q = '{8'h01, 8'h02};
        send_msg(1'b0, 1'b0);
        // A register write in the middle of a message drops what is held.
        send_item(8'h07, 1'b1, 1'b0);
        apply_settings(bpc_pkg::MODE_PAD, 6'd8);

        // Long receiver hold-off while a long message keeps coming.
        hold_off_req = 1'b1;
        msg_q.delete();
        repeat (40) msg_q.push_back(BYTE_W'($urandom));
        send_msg(1'b0, 1'b0);

        random_end = items_sent + RANDOM_ITEMS;
        phase_idx = 0;
        while (items_sent < random_end) begin
            mode = logic'($urandom_range(0, 1));
            r = $urandom_range(0, 9);
            if (r == 0) begin
                size = 6'd32;
            end else if (r == 1) begin
                size = ($urandom_range(0, 1) == 0) ? 6'd0 : CFG_W'($urandom_range(33, 63));
            end else begin
                size = CFG_W'($urandom_range(1, 8));
            end
            if (phase_idx == 0) begin
                mode = bpc_pkg::MODE_UNPAD;
                size = 6'd32;
            end
            apply_settings(mode, size);
            in_gaps_on = $urandom_range(0, 3) != 0;
            out_gaps_on = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(1, 4)) begin
                if (items_sent < random_end) begin
                    if (mode == bpc_pkg::MODE_PAD) begin
                        build_pad(sb.block_len());
                    end else begin
                        build_unpad(sb.block_len());
                    end
                    send_msg($urandom_range(0, 3) == 0, 1'b1);
                end
            end
            phase_idx++;
        end
        s_valid <= 1'b0;

        drain = 0;
        while (sb.pending() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        if (sb.pending() != 0) begin
            sb.flag($sformatf("%0d expected results never arrived", sb.pending()));
        end
        repeat (QUIET_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
